>>> hdl/jacobi_matrix_rotation_unit_macros.svh
// Assertion macros shared by the rotation unit.
`ifndef JACOBI_MATRIX_ROTATION_UNIT_MACROS_SVH
`define JACOBI_MATRIX_ROTATION_UNIT_MACROS_SVH
`ifndef SYNTH
// Property must hold on every clock edge outside reset.
`define JMR_CHECK(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be seen outside reset.
`define JMR_NEVER(lbl, clk_i, rst_ni, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define JMR_CHECK(lbl, clk_i, rst_ni, prop, msg)
`define JMR_NEVER(lbl, clk_i, rst_ni, cond, msg)
`endif
`endif

>>> hdl/jmr_pkg.sv
`timescale 1ns / 1ps
package jmr_pkg;
	localparam int DATA_W = 32;
	localparam int ACC_W  = 65;

	typedef logic [1:0] action_t;
	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_READ  = 2'd1;
	localparam action_t ACT_ROT2  = 2'd2;
	localparam action_t ACT_ROT1  = 2'd3;

	typedef logic [1:0] addr_sel_t;
	localparam addr_sel_t ADDR_ELEM = 2'd0;
	localparam addr_sel_t ADDR_A    = 2'd1;
	localparam addr_sel_t ADDR_B    = 2'd2;

	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MUL_CA = 2'd0;
	localparam mul_sel_t MUL_SB = 2'd1;
	localparam mul_sel_t MUL_CB = 2'd2;
	localparam mul_sel_t MUL_SA = 2'd3;

	typedef logic [1:0] acc_op_t;
	localparam acc_op_t ACC_HOLD = 2'd0;
	localparam acc_op_t ACC_LOAD = 2'd1;
	localparam acc_op_t ACC_SUB  = 2'd2;
	localparam acc_op_t ACC_ADD  = 2'd3;

	typedef logic [1:0] wr_sel_t;
	localparam wr_sel_t WR_ITEM = 2'd0;
	localparam wr_sel_t WR_U    = 2'd1;
	localparam wr_sel_t WR_V    = 2'd2;

	typedef struct packed {
		logic      ld_item;
		logic      mem_rd;
		logic      mem_wr;
		addr_sel_t addr_sel;
		logic      col_phase;
		mul_sel_t  mul_sel;
		acc_op_t   acc_op;
		logic      cap_a;
		logic      cap_b;
		logic      cap_u;
		wr_sel_t   wr_sel;
		logic      ld_out;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    in_range;
		logic    same_idx;
	} stat_t;

	// Round to nearest (ties up) from Q.46 sum to Q15.16, then saturate.
	function automatic logic [DATA_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] t;
		logic signed [35:0]    q;
		t = (ACC_W+1)'(acc) + (ACC_W+1)'(64'sd536870912);
		q = 36'(t >>> 30);
		if (q > 36'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (q < -36'sd2147483648)
			return 32'h8000_0000;
		else
			return q[DATA_W-1:0];
	endfunction
endpackage

>>> hdl/jmr_datapath.sv
`timescale 1ns / 1ps
module jmr_datapath #(
	parameter int MAT_DIM = 16,
	parameter int RW = 4,
	parameter int CW = 5
) (
	input  logic                clk,
	input  jmr_pkg::cmd_t       cmd,
	output jmr_pkg::stat_t      stat,
	input  logic [RW-1:0]       j_idx,
	input  logic [CW-1:0]       n,
	input  logic [1:0]          action,
	input  logic [3:0]          first_index,
	input  logic [3:0]          second_index,
	input  logic signed [31:0]  cos_value,
	input  logic signed [31:0]  sin_value,
	input  logic signed [31:0]  write_value,
	output logic signed [31:0]  read_value
);
	import jmr_pkg::*;

	localparam int DEPTH = MAT_DIM * MAT_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = (CW > 4) ? CW : 4;

	logic [1:0]               act_q;
	logic [3:0]               u_q, v_q;
	logic signed [31:0]       c_q, s_q, w_q;
	logic signed [31:0]       a_q, b_q, rd_q, resu_q, out_q;
	logic signed [63:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [31:0]              mem [DEPTH];
	logic [AW-1:0]            addr;
	logic [31:0]              wdata;
	logic signed [31:0]       op_x, op_y;
	logic                     in_range;

	function automatic logic [AW-1:0] elem_addr(input logic [AW-1:0] row,
	                                            input logic [AW-1:0] col);
		return AW'(row * AW'(MAT_DIM)) + col;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			act_q <= action;
			u_q   <= first_index;
			v_q   <= second_index;
			c_q   <= cos_value;
			s_q   <= sin_value;
			w_q   <= write_value;
		end
	end

	assign in_range = (IW'(u_q) < IW'(n)) && (IW'(v_q) < IW'(n));
	assign stat.act = act_q;
	assign stat.in_range = in_range;
	assign stat.same_idx = (u_q == v_q);

	always_comb begin
		case (cmd.addr_sel)
			ADDR_ELEM: addr = elem_addr(AW'(u_q), AW'(v_q));
			ADDR_A:    addr = cmd.col_phase ? elem_addr(AW'(j_idx), AW'(u_q))
			                                : elem_addr(AW'(u_q), AW'(j_idx));
			ADDR_B:    addr = cmd.col_phase ? elem_addr(AW'(j_idx), AW'(v_q))
			                                : elem_addr(AW'(v_q), AW'(j_idx));
			default:   addr = '0;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_ITEM: wdata = w_q;
			WR_U:    wdata = resu_q;
			WR_V:    wdata = rnd_sat(acc_q);
			default: wdata = w_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr)
			mem[addr] <= wdata;
		if (cmd.mem_rd)
			rd_q <= mem[addr];
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_CA:  begin op_x = c_q; op_y = a_q; end
			MUL_SB:  begin op_x = s_q; op_y = b_q; end
			MUL_CB:  begin op_x = c_q; op_y = b_q; end
			MUL_SA:  begin op_x = s_q; op_y = a_q; end
			default: begin op_x = c_q; op_y = a_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_x * op_y;
		if (cmd.cap_a)
			a_q <= rd_q;
		if (cmd.cap_b)
			b_q <= rd_q;
		if (cmd.cap_u)
			resu_q <= rnd_sat(acc_q);
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  acc_q <= acc_q;
		endcase
		if (cmd.ld_out)
			out_q <= in_range ? rd_q : 32'sd0;
	end

	assign read_value = out_q;
endmodule

>>> hdl/jmr_ctrl.sv
`timescale 1ns / 1ps
`include "jacobi_matrix_rotation_unit_macros.svh"
module jmr_ctrl #(
	parameter int RW = 4,
	parameter int CW = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           res_valid,
	input  logic           res_ready,
	input  logic [CW-1:0]  n,
	input  jmr_pkg::stat_t stat,
	output jmr_pkg::cmd_t  cmd,
	output logic [RW-1:0]  j_idx
);
	import jmr_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RDW  = 4'd2;
	localparam logic [3:0] S_RDA  = 4'd3;
	localparam logic [3:0] S_RDB  = 4'd4;
	localparam logic [3:0] S_M1   = 4'd5;
	localparam logic [3:0] S_M2   = 4'd6;
	localparam logic [3:0] S_M3   = 4'd7;
	localparam logic [3:0] S_M4   = 4'd8;
	localparam logic [3:0] S_W1   = 4'd9;
	localparam logic [3:0] S_W2   = 4'd10;

	logic [3:0]    state_q, state_d;
	logic [RW-1:0] j_q, j_d;
	logic          col_q, col_d;
	logic          out_valid_q, out_valid_d;
	logic          last_j;

	assign last_j = (CW'(j_q) == n - CW'(1));
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = out_valid_q;
	assign j_idx = j_q;

	always_comb begin
		cmd = '0;
		cmd.col_phase = col_q;
		state_d = state_q;
		j_d = j_q;
		col_d = col_q;
		out_valid_d = out_valid_q && !res_ready;
		case (state_q)
			S_IDLE: begin
				cmd.ld_item = req_valid;
				if (req_valid)
					state_d = S_DEC;
			end
			S_DEC: begin
				cmd.addr_sel = ADDR_ELEM;
				cmd.wr_sel = WR_ITEM;
				if (stat.act == ACT_WRITE) begin
					cmd.mem_wr = stat.in_range;
					state_d = S_IDLE;
				end else if (stat.act == ACT_READ) begin
					cmd.mem_rd = 1'b1;
					state_d = S_RDW;
				end else if (stat.in_range && !stat.same_idx) begin
					j_d = '0;
					col_d = 1'b0;
					state_d = S_RDA;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RDW: begin
				if (!out_valid_q || res_ready) begin
					cmd.ld_out = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RDA: begin
				cmd.mem_rd = 1'b1;
				cmd.addr_sel = ADDR_A;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.mem_rd = 1'b1;
				cmd.addr_sel = ADDR_B;
				cmd.cap_a = 1'b1;
				state_d = S_M1;
			end
			S_M1: begin
				cmd.cap_b = 1'b1;
				cmd.mul_sel = MUL_CA;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.mul_sel = MUL_SB;
				cmd.acc_op = ACC_LOAD;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.mul_sel = MUL_CB;
				cmd.acc_op = ACC_SUB;
				state_d = S_M4;
			end
			S_M4: begin
				cmd.mul_sel = MUL_SA;
				cmd.acc_op = ACC_LOAD;
				cmd.cap_u = 1'b1;
				state_d = S_W1;
			end
			S_W1: begin
				cmd.acc_op = ACC_ADD;
				cmd.mem_wr = 1'b1;
				cmd.addr_sel = ADDR_A;
				cmd.wr_sel = WR_U;
				state_d = S_W2;
			end
			S_W2: begin
				cmd.mem_wr = 1'b1;
				cmd.addr_sel = ADDR_B;
				cmd.wr_sel = WR_V;
				if (!last_j) begin
					j_d = j_q + RW'(1);
					state_d = S_RDA;
				end else if (!col_q && stat.act == ACT_ROT2) begin
					j_d = '0;
					col_d = 1'b1;
					state_d = S_RDA;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			col_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q <= j_d;
			col_q <= col_d;
			out_valid_q <= out_valid_d;
		end
	end

	`JMR_CHECK(a_accept_dec, clk, arst_n, (req_valid && req_ready) |=> (state_q == S_DEC), "accepted request not decoded")
	`JMR_CHECK(a_rsp_from_rdw, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == S_RDW), "response raised outside read")
	`JMR_CHECK(a_j_in_range, clk, arst_n, (state_q == S_RDA) |-> (CW'(j_q) < n), "element counter beyond size")
	`JMR_NEVER(a_rd_wr, clk, arst_n, cmd.mem_rd && cmd.mem_wr, "store read and write together")
endmodule

>>> hdl/jacobi_matrix_rotation_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake                   | Payload
// request   | req_valid / req_ready       | action, first_index, second_index,
//           |                             | cos_value, sin_value, write_value
// response  | res_valid / res_ready       | read_value
// config    | APB psel/penable/pwrite     | paddr, pwdata, prdata (matrix_size @ 0x0)
//
// A read may also wait for the response slot. A row-only rotation sweeps n
// elements of the two rows, a two-sided rotation also of the two columns (n = effective size).
// Rotation cost is set by the single-port element store and the one shared
// 32x32 multiplier: four products and two writes per element pair.
// One request in flight; req_ready is high while the sequencer is idle, even
// with a response still waiting. Reset clears control and sets matrix_size 16;
// the element store is not cleared.
module jacobi_matrix_rotation_unit #(
	parameter int MAT_DIM = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         action,
	input  logic [3:0]         first_index,
	input  logic [3:0]         second_index,
	input  logic signed [31:0] cos_value,
	input  logic signed [31:0] sin_value,
	input  logic signed [31:0] write_value,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] read_value,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import jmr_pkg::*;

	// row/column index width and a count width that holds the size itself
	localparam int RW = $clog2(MAT_DIM);
	localparam int CW = $clog2(MAT_DIM + 1);

	logic [4:0]    size_q;
	logic [CW-1:0] n;
	cmd_t          cmd;
	stat_t         stat;
	logic [RW-1:0] j_idx;

	// Config register: only word 0 exists, other words read zero.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= 5'd16;
		else if (psel && penable && pwrite && !paddr[2])
			size_q <= pwdata[4:0];
	end
	assign prdata = paddr[2] ? 32'd0 : {27'd0, size_q};

	// effective size, capped at the store dimension
	assign n = (32'(size_q) > MAT_DIM) ? CW'(MAT_DIM) : CW'(size_q);

	jmr_ctrl #(.RW(RW), .CW(CW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.n         (n),
		.stat      (stat),
		.cmd       (cmd),
		.j_idx     (j_idx)
	);

	jmr_datapath #(.MAT_DIM(MAT_DIM), .RW(RW), .CW(CW)) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.j_idx        (j_idx),
		.n            (n),
		.action       (action),
		.first_index  (first_index),
		.second_index (second_index),
		.cos_value    (cos_value),
		.sin_value    (sin_value),
		.write_value  (write_value),
		.read_value   (read_value)
	);
endmodule
